// ===== sv/sparse_lower_triangular_solve_defines.svh =====
// Assertion macros shared by the sparse lower-triangular solver modules.
// No dependencies.
`ifndef SPARSE_LOWER_TRIANGULAR_SOLVE_DEFINES_SVH
`define SPARSE_LOWER_TRIANGULAR_SOLVE_DEFINES_SVH
// implication checked every clock outside reset
`define SLTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slts check failed");
// implication checked with the consequent in the next clock
`define SLTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slts check failed");
`endif

// ===== sv/slts_pkg.sv =====
// Package for the sparse lower-triangular solver: widths, codes, command types.
// No dependencies.
package slts_pkg;
  localparam int MAX_ROWS = 4096;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CNT_W = ROW_W + 1;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W = 64;
  localparam int QCNT_W = $clog2(ACC_W + 1);

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIAG = 2'd1;
  localparam logic [1:0] ERR_NEIGHBOUR = 2'd2;
  localparam logic [1:0] ERR_SAT = 2'd3;

  typedef struct packed {
    logic take;     // latch input item, issue store read
    logic mac;      // apply latched item to accumulator
    logic div_start;
    logic div_step;
    logic finish;   // commit result to output register
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic div_done;
    logic out_full;
  } sts_t;
endpackage

// ===== sv/slts_datapath.sv =====
// Datapath of the sparse lower-triangular solver: store, multiply-subtract,
// restoring divider, output register. Uses slts_pkg.
`include "sparse_lower_triangular_solve_defines.svh"
module slts_datapath (
  input  logic clk,
  input  logic rst,
  input  slts_pkg::cmd_t cmd,
  output slts_pkg::sts_t sts,
  input  logic in_start_vector,
  input  logic in_row_first,
  input  logic signed [slts_pkg::VALUE_WIDTH-1:0] in_rhs_value,
  input  logic signed [slts_pkg::VALUE_WIDTH-1:0] in_coeff,
  input  logic [slts_pkg::ROW_W-1:0] in_neighbor_row,
  input  logic in_row_last,
  output logic signed [slts_pkg::VALUE_WIDTH-1:0] solution_value,
  output logic [slts_pkg::ROW_W-1:0] solution_row,
  output logic [1:0] error_code
);
  localparam int VW = slts_pkg::VALUE_WIDTH;
  localparam int AW = slts_pkg::ACC_W;
  localparam int RW = slts_pkg::ROW_W;
  localparam int CW = slts_pkg::CNT_W;

  logic signed [VW-1:0] store [slts_pkg::MAX_ROWS];
  logic signed [VW-1:0] rd_data;

  // latched item
  logic first_q, last_q, nb_bad;
  logic signed [VW-1:0] rhs_q, coeff_q;

  logic [CW-1:0] current_row;
  logic signed [AW-1:0] acc;
  logic signed [VW-1:0] diag;
  logic [1:0] row_error;

  // divider
  logic [AW-1:0] dq, drem;
  logic [VW-1:0] ddiv;
  logic dneg;
  logic [slts_pkg::QCNT_W-1:0] dcnt;

  logic out_full;

  // row counter after start_vector at take time
  logic [CW-1:0] row_eff;
  assign row_eff = in_start_vector ? '0 : current_row;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_data <= store[in_neighbor_row];
      first_q <= in_row_first;
      last_q <= in_row_last;
      rhs_q <= in_rhs_value;
      coeff_q <= in_coeff;
      nb_bad <= ({1'b0, in_neighbor_row} >= row_eff);
    end
  end

  // 64-bit product: 32x32 signed fits exactly; rhs << FRAC never saturates
  logic signed [2*VW-1:0] prod;
  logic signed [AW-1:0] prod_x, diff;
  logic sub_ovf;
  always_comb begin
    prod = coeff_q * rd_data;
    prod_x = AW'(prod);
    diff = acc - prod_x;
    sub_ovf = (acc[AW-1] != prod_x[AW-1]) && (diff[AW-1] != acc[AW-1]);
  end

  // division step
  logic [AW:0] trial;
  logic [AW-1:0] rem_sh;
  always_comb begin
    rem_sh = {drem[AW-2:0], dq[AW-1]};
    trial = {1'b0, rem_sh} - {{(AW+1-VW){1'b0}}, ddiv};
  end

  // saturation of quotient
  logic [AW-1:0] qmag;
  logic qsat;
  logic signed [VW-1:0] qval;
  localparam logic [AW-1:0] VMAXM = AW'((64'd1 << (VW-1)) - 64'd1);
  always_comb begin
    qmag = dq;
    if (dneg) begin
      qsat = qmag > (VMAXM + AW'(1));
      qval = qsat ? {1'b1, {(VW-1){1'b0}}} : VW'(-qmag);
    end else begin
      qsat = qmag > VMAXM;
      qval = qsat ? VW'(VMAXM) : VW'(qmag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      acc <= '0;
      diag <= '0;
      row_error <= slts_pkg::ERR_OK;
      out_full <= 1'b0;
    end else begin
      if (cmd.take && in_start_vector) current_row <= '0;
      if (cmd.mac) begin
        if (first_q) begin
          row_error <= slts_pkg::ERR_OK;
          diag <= coeff_q;
          acc <= AW'(rhs_q) <<< slts_pkg::FRAC_BITS;
        end else if (nb_bad) begin
          if (row_error == slts_pkg::ERR_OK) row_error <= slts_pkg::ERR_NEIGHBOUR;
        end else if (sub_ovf) begin
          acc <= acc[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
          if (row_error == slts_pkg::ERR_OK) row_error <= slts_pkg::ERR_SAT;
        end else begin
          acc <= diff;
        end
      end
      if (cmd.finish) begin
        out_full <= 1'b1;
        if (diag == '0) begin
          solution_value <= '0;
          error_code <= slts_pkg::ERR_ZERO_DIAG;
        end else begin
          solution_value <= qval;
          error_code <= (row_error == slts_pkg::ERR_OK && qsat) ? slts_pkg::ERR_SAT
                                                                : row_error;
        end
        solution_row <= current_row[RW-1:0];
        if (current_row < CW'(slts_pkg::MAX_ROWS)) current_row <= current_row + CW'(1);
        acc <= '0;
        diag <= '0;
        row_error <= slts_pkg::ERR_OK;
      end else if (cmd.out_pop) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && current_row < CW'(slts_pkg::MAX_ROWS))
      store[current_row[RW-1:0]] <= (diag == '0) ? '0 : qval;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= acc[AW-1] ? AW'(-acc) : acc;
      drem <= '0;
      ddiv <= diag[VW-1] ? VW'(-diag) : diag;
      dneg <= acc[AW-1] != diag[VW-1];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[AW]) begin
        drem <= trial[AW-1:0];
        dq <= {dq[AW-2:0], 1'b1};
      end else begin
        drem <= rem_sh;
        dq <= {dq[AW-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
  end

  assign sts.is_last = last_q;
  assign sts.div_done = (dcnt == slts_pkg::QCNT_W'(AW));
  assign sts.out_full = out_full;

  `SLTS_ASSERT_NEXT(a_row_sat, cmd.finish && current_row == CW'(slts_pkg::MAX_ROWS),
                    current_row == CW'(slts_pkg::MAX_ROWS))
  `SLTS_ASSERT_IMP(a_no_finish_full, cmd.finish, !out_full || cmd.out_pop)
  `SLTS_ASSERT_IMP(a_err_code, out_full && solution_value != '0,
                   error_code != slts_pkg::ERR_ZERO_DIAG)
endmodule

// ===== sv/slts_ctrl.sv =====
// Controller of the sparse lower-triangular solver: handshake and sequencing.
// Uses slts_pkg.
`include "sparse_lower_triangular_solve_defines.svh"
module slts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output slts_pkg::cmd_t cmd,
  input  slts_pkg::sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic pop;

  assign pop = sts.out_full && out_ready;
  assign out_valid = sts.out_full;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_pop = pop;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        state_next = S_IDLE;
        if (sts.is_last) state_next = S_LOAD;
      end
      S_LOAD: begin
        // acc/diag final after MAC; load divider operands
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = !sts.div_done;
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full || pop) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SLTS_ASSERT_IMP(a_take_idle, cmd.take, state == S_IDLE)
  `SLTS_ASSERT_NEXT(a_mac_after_take, cmd.take, state == S_MAC)
  `SLTS_ASSERT_NEXT(a_div_after_load, cmd.div_start, state == S_DIV)
endmodule

// ===== sv/sparse_lower_triangular_solve.sv =====
// Top level of the sparse lower-triangular forward-substitution solver.
// Depends on slts_pkg, slts_ctrl, slts_datapath.
//
// Usage: one input item per factor entry, valid/ready. A row opens with its
// diagonal entry (row_first, rhs_value, coeff); further entries subtract
// coeff times the stored solution of neighbor_row. On row_last the row is
// divided by the diagonal and one result item (solution_value, solution_row,
// error_code) appears on the valid/ready output channel.
// Sequencing: a non-final entry is taken with its store read, then applied by
// the multiply-subtract; in_ready is low while it is applied. A final entry
// goes on to a divider load, the 64 steps of the bit-serial restoring
// divider, a state that sees the divider done and a commit, before the next
// input can be accepted. out_valid rises once that commit has been made.
// The output register holds a result while the receiver stalls; input is
// still accepted then, until the next row's result needs that register; the
// commit then waits until the receiver takes the held result.
// Reset clears the row counter, accumulator, diagonal and error; the
// solution store is not cleared and holds rows as they are solved.
module sparse_lower_triangular_solve (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic start_vector,
  input  logic row_first,
  input  logic signed [31:0] rhs_value,
  input  logic signed [31:0] coeff,
  input  logic [11:0] neighbor_row,
  input  logic row_last,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] solution_value,
  output logic [11:0] solution_row,
  output logic [1:0] error_code
);
  slts_pkg::cmd_t cmd;
  slts_pkg::sts_t sts;

  slts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  slts_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_start_vector(start_vector), .in_row_first(row_first),
    .in_rhs_value(rhs_value), .in_coeff(coeff), .in_neighbor_row(neighbor_row),
    .in_row_last(row_last), .solution_value(solution_value),
    .solution_row(solution_row), .error_code(error_code)
  );
endmodule
